/* src/aabbfc_pkg.sv */
package aabbfc_pkg;

  // default configuration
  localparam int unsigned NumPlanesDef = 6;
  localparam int unsigned FracBitsDef  = 16;

  // field widths
  localparam int unsigned CoefW        = 32;
  localparam int unsigned PlaneIdxW    = 3;
  localparam int unsigned CoefIdxW     = 2;
  localparam int unsigned CoefPerPlane = 4;
  localparam int unsigned NumAxes      = 3;
  localparam int unsigned ProdW        = 2 * CoefW;
  localparam int unsigned SumW         = ProdW + 2;

  // input tdata layout, lowest bit first
  localparam int unsigned PlaneOffs    = 0;
  localparam int unsigned CoefIdxOffs  = PlaneOffs + PlaneIdxW;
  localparam int unsigned CoefValOffs  = CoefIdxOffs + CoefIdxW;
  localparam int unsigned BoxLowOffs   = CoefValOffs + CoefW;
  localparam int unsigned BoxHighOffs  = BoxLowOffs + NumAxes * CoefW;
  localparam int unsigned InBits       = BoxHighOffs + NumAxes * CoefW;
  localparam int unsigned TdataInW     = ((InBits + 7) / 8) * 8;
  localparam int unsigned TuserInW     = 1;
  localparam int unsigned TdataOutW    = 8;

  // item kinds carried in tuser
  typedef enum logic [TuserInW-1:0] {
    FUNC_LOAD = 1'b0,
    FUNC_TEST = 1'b1
  } func_e;

  // controller to datapath commands
  typedef struct packed {
    logic                 coef_we;
    logic                 box_load;
    logic                 issue;
    logic [PlaneIdxW-1:0] plane;
    logic                 out_load;
  } cmd_t;

endpackage

/* src/aabbfc_dp.sv */
module aabbfc_dp #(
  parameter int unsigned NUM_PLANES = aabbfc_pkg::NumPlanesDef,
  parameter int unsigned FRAC_BITS  = aabbfc_pkg::FracBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  aabbfc_pkg::cmd_t                cmd_i,
  input  logic [aabbfc_pkg::TdataInW-1:0] tdata_i,
  output logic                            visible_o
);
  import aabbfc_pkg::*;

  localparam int unsigned PlaneW = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
  localparam logic [PlaneIdxW:0] NumPlanesV = (PlaneIdxW + 1)'(NUM_PLANES);

  logic signed [CoefW-1:0] coef_q [NUM_PLANES][CoefPerPlane];
  logic signed [CoefW-1:0] row    [CoefPerPlane];

  logic [PlaneIdxW-1:0]    in_plane;
  logic [CoefIdxW-1:0]     in_coef;
  logic signed [CoefW-1:0] in_val;
  logic signed [CoefW-1:0] lo_in  [NumAxes];
  logic signed [CoefW-1:0] hi_in  [NumAxes];
  logic signed [CoefW-1:0] big_q  [NumAxes];
  logic signed [CoefW-1:0] small_q[NumAxes];
  logic signed [CoefW-1:0] sel    [NumAxes];

  logic signed [ProdW-1:0] prod_d [NumAxes];
  logic signed [ProdW-1:0] prod_q [NumAxes];
  logic signed [ProdW-1:0] dsh_d, dsh_q;
  logic signed [SumW-1:0]  sum;
  logic                    pv_q;
  logic                    plane_cull;
  logic                    cull_q;
  logic                    vis_q;

  assign in_plane = tdata_i[PlaneOffs +: PlaneIdxW];
  assign in_coef  = tdata_i[CoefIdxOffs +: CoefIdxW];
  assign in_val   = tdata_i[CoefValOffs +: CoefW];

  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      lo_in[a] = tdata_i[BoxLowOffs + a * CoefW +: CoefW];
      hi_in[a] = tdata_i[BoxHighOffs + a * CoefW +: CoefW];
    end
  end

  // plane store, one coefficient written per load
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        for (int k = 0; k < CoefPerPlane; k++) begin
          coef_q[p][k] <= '0;
        end
      end
    end else if (cmd_i.coef_we && ({1'b0, in_plane} < NumPlanesV)) begin
      coef_q[in_plane[PlaneW-1:0]][in_coef] <= in_val;
    end
  end

  // box kept as per-axis max and min
  always_ff @(posedge clk_i) begin
    if (cmd_i.box_load) begin
      for (int a = 0; a < NumAxes; a++) begin
        big_q[a]   <= (lo_in[a] > hi_in[a]) ? lo_in[a] : hi_in[a];
        small_q[a] <= (lo_in[a] > hi_in[a]) ? hi_in[a] : lo_in[a];
      end
    end
  end

  // stage 1: favored corner and products for one plane
  always_comb begin
    row = coef_q[cmd_i.plane[PlaneW-1:0]];
    for (int a = 0; a < NumAxes; a++) begin
      sel[a]    = row[a][CoefW-1] ? small_q[a] : big_q[a];
      prod_d[a] = row[a] * sel[a];
    end
    dsh_d = ProdW'(row[NumAxes]) <<< FRAC_BITS;
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < NumAxes; a++) begin
      prod_q[a] <= prod_d[a];
    end
    dsh_q <= dsh_d;
  end

  // stage 2: plane sum and sign test
  assign sum = SumW'(prod_q[0]) + SumW'(prod_q[1]) + SumW'(prod_q[2]) + SumW'(dsh_q);
  assign plane_cull = sum[SumW-1] | (sum == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q   <= 1'b0;
      cull_q <= 1'b0;
    end else begin
      pv_q <= cmd_i.issue;
      if (cmd_i.box_load) begin
        cull_q <= 1'b0;
      end else if (pv_q) begin
        cull_q <= cull_q | plane_cull;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      vis_q <= ~(cull_q | (pv_q & plane_cull));
    end
  end

  assign visible_o = vis_q;

endmodule

/* src/aabbfc_ctrl.sv */
module aabbfc_ctrl #(
  parameter int unsigned NUM_PLANES = aabbfc_pkg::NumPlanesDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_tvalid_i,
  output logic                            s_tready_o,
  input  logic [aabbfc_pkg::TuserInW-1:0] s_func_i,
  output logic                            m_tvalid_o,
  input  logic                            m_tready_i,
  output aabbfc_pkg::cmd_t                cmd_o
);
  import aabbfc_pkg::*;

  localparam int unsigned PlaneW = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
  localparam logic [PlaneW-1:0] LastPlane = PlaneW'(NUM_PLANES - 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RUN  = 4'b0010,
    ST_LAST = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [PlaneW-1:0] cnt_q, cnt_d;
  logic              ovld_q, ovld_d;
  logic              accept;
  logic              out_free;

  assign accept   = s_tvalid_i & s_tready_o;
  assign out_free = ~ovld_q | m_tready_i;

  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    s_tready_o     = 1'b0;
    cmd_o          = '0;
    cmd_o.plane    = PlaneIdxW'(cnt_q);
    ovld_d         = ovld_q & ~m_tready_i;
    case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (accept) begin
          if (s_func_i == FUNC_TEST) begin
            cmd_o.box_load = 1'b1;
            cnt_d          = '0;
            state_d        = ST_RUN;
          end else begin
            cmd_o.coef_we = 1'b1;
          end
        end
      end
      ST_RUN: begin
        cmd_o.issue = 1'b1;
        if (cnt_q == LastPlane) begin
          state_d = ST_LAST;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_LAST: begin
        if (out_free) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        cmd_o.out_load = 1'b1;
        ovld_d         = 1'b1;
        state_d        = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovld_q  <= ovld_d;
    end
  end

  assign m_tvalid_o = ovld_q;

endmodule

/* src/aabb_frustum_cull_test_unit.sv */
// channel   dir  tdata (lsb first)                               tuser
// s_axis    in   plane_index[3] coef_index[2] coef_value[32]     func[1]
//                box_x/y/z_low[32 each] box_x/y/z_high[32 each]
//                zero pad to 232 bits
// m_axis    out  visible[1], zero pad to 8 bits                  -
//
// a load transaction writes one plane coefficient and gives no result
// a test transaction blocks the input until its result is loaded: the planes step
//   one at a time through the shared three-multiplier product stage,
//   then the last plane's sum stage and the output register load
// the result register holds one finished result, so loads and the next test proceed
//   while it waits; a test only stalls at its end if the previous result is still held
// reset (rst_ni low, asynchronous) clears all plane coefficients, so every box is culled
module aabb_frustum_cull_test_unit #(
  parameter int unsigned NUM_PLANES = aabbfc_pkg::NumPlanesDef,
  parameter int unsigned FRAC_BITS  = aabbfc_pkg::FracBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // plane_index, coef_index, coef_value, box_x_low, box_y_low, box_z_low,
  // box_x_high, box_y_high, box_z_high
  input  logic [aabbfc_pkg::TdataInW-1:0]  s_axis_tdata_i,
  // func
  input  logic [aabbfc_pkg::TuserInW-1:0]  s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // visible
  output logic [aabbfc_pkg::TdataOutW-1:0] m_axis_tdata_o
);
  import aabbfc_pkg::*;

  cmd_t cmd;
  logic visible;

  // sequencer: accepts transactions, steps the plane counter, owns result valid
  aabbfc_ctrl #(
    .NUM_PLANES(NUM_PLANES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .s_func_i   (s_axis_tuser_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .cmd_o      (cmd)
  );

  // plane store, box registers, product and sum stages, result bit
  aabbfc_dp #(
    .NUM_PLANES(NUM_PLANES),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .tdata_i   (s_axis_tdata_i),
    .visible_o (visible)
  );

  // visible in bit 0, the rest zero
  assign m_axis_tdata_o = {{(TdataOutW - 1){1'b0}}, visible};

endmodule

/* src/aabbfc_chk.sv */
module aabbfc_chk (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid_i,
  input logic                             s_axis_tready_o,
  input logic [aabbfc_pkg::TuserInW-1:0]  s_axis_tuser_i,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [aabbfc_pkg::TdataOutW-1:0] m_axis_tdata_o
);
  import aabbfc_pkg::*;

  // a held result stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result dropped or changed while stalled");

  // a test transaction occupies the block for the following cycle
  a_test_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == FUNC_TEST)
    |=> !s_axis_tready_o)
    else $error("input taken right after a test transaction");

  // a load transaction never stalls the input
  a_load_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == FUNC_LOAD)
    |=> s_axis_tready_o)
    else $error("load transaction stalled the input");

  // a new result only comes out of a test still in progress
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(!s_axis_tready_o))
    else $error("result appeared without a test in progress");

endmodule

bind aabb_frustum_cull_test_unit aabbfc_chk u_aabbfc_chk (.*);
